@@ hw/rtl/graph_component_search_assert.svh @@
// Assertion macros for the graph component search block.
// Each macro expands to one labeled concurrent assertion; no other dependencies.
`ifndef GRAPH_COMPONENT_SEARCH_ASSERT_SVH
`define GRAPH_COMPONENT_SEARCH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("graph_component_search: assertion failed");

// Next-cycle implication, checked outside reset.
`define GCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("graph_component_search: assertion failed");

`endif

@@ hw/rtl/gcs_pkg.sv @@
// Shared types and codes for the graph component search block.
// Used by graph_component_search; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package gcs_pkg;

	localparam int NODE_W = 5;
	localparam int ROW_W  = 32;
	localparam int CFG_W  = 6;
	localparam int REQ_W  = 2;

	localparam logic [REQ_W-1:0] REQ_WRITE_ROW = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH    = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [NODE_W-1:0] node_index;
		logic [ROW_W-1:0]  row_bits;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0] member;
		logic              last;
	} rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/graph_component_search.sv @@
// Graph component search: adjacency matrix, visited marks and a depth-first walk.
// Depends on gcs_pkg and graph_component_search_assert.svh.
//
// Usage: requests arrive on req (valid/stall), results leave on rsp (valid/stall),
// and the node count register is written on cfg_valid/cfg_ready/cfg_data.
// A row write or a clear of the visited marks gives no result.
// A search holds req_stall high until its last member has been handed to the
// output register. One sequencer drives the walk: after the transfer, each newly
// visited node is marked, then its unvisited neighbors are pushed, lowest first,
// while the stack has room; each pop reads the stack memory, then checks whether
// that node is visited, and finding the stack empty hands over the last member.
// The next request can transfer once req_stall has fallen.
// Members leave one behind the walk, since a member is flagged last only once the
// stack has run empty; while the receiver stalls, the walk runs on until one member
// sits in the output register and one is pending, and then the walk waits.
// Reset clears the matrix, the visited marks and the stack pointer and sets the
// node count to its largest value; stack memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module graph_component_search #(
	parameter int MAX_NODES   = 32,
	parameter int STACK_DEPTH = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire gcs_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output gcs_pkg::rsp_t      rsp,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [gcs_pkg::CFG_W-1:0] cfg_data
);
	import gcs_pkg::*;

	localparam int ROWS  = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
	localparam int RIW   = $clog2(ROWS);
	localparam int SP_W  = $clog2(STACK_DEPTH + 1);
	localparam int SA_W  = $clog2(STACK_DEPTH);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_VISIT  = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_POP    = 3'd3;
	localparam logic [2:0] ST_CHECK  = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]        st_q;
	logic [CFG_W-1:0]  n_q;
	logic [ROW_W-1:0]  adj_q [ROWS];
	logic [ROWS-1:0]   visited_q;
	logic [SP_W-1:0]   sp_q;
	logic [NODE_W-1:0] node_q;
	logic [ROW_W-1:0]  cand_q;
	logic [NODE_W-1:0] pend_q;
	logic              pend_valid_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic [NODE_W-1:0] rd_q;
	logic [NODE_W-1:0] stack_mem [STACK_DEPTH];

	logic [ROW_W-1:0]  vis32;
	logic [ROW_W-1:0]  nmask;
	logic [ROW_W-1:0]  cand_next;
	logic [NODE_W-1:0] low_idx;
	logic [SP_W-1:0]   sp_dec;
	logic [CFG_W-1:0]  cfg_clamped;
	logic              out_free;
	logic              visit_go;
	logic              visit_fire;
	logic              rsp_load;
	logic              push_en;
	logic              pop_en;

	// Nodes beyond the stored rows look visited, so they are never pushed.
	for (genvar g = 0; g < ROW_W; g++) begin : g_vis
		if (g < ROWS) begin : g_real
			assign vis32[g] = visited_q[g];
		end else begin : g_none
			assign vis32[g] = 1'b1;
		end
	end

	always_comb begin
		for (int d = 0; d < ROW_W; d++) begin
			nmask[d] = (CFG_W'(d) < n_q);
		end
	end

	// Lowest set bit of the pending neighbor set: pushed first, popped last.
	always_comb begin
		low_idx = '0;
		for (int d = ROW_W - 1; d >= 0; d--) begin
			if (cand_q[d]) begin
				low_idx = NODE_W'(d);
			end
		end
	end

	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamped = CFG_W'(1);
		end else if (cfg_data > CFG_W'(ROWS)) begin
			cfg_clamped = CFG_W'(ROWS);
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	assign cand_next = adj_q[node_q[RIW-1:0]] & nmask & ~vis32
		& ~(ROW_W'(1) << node_q);
	assign sp_dec    = sp_q - SP_W'(1);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign visit_go  = !pend_valid_q || out_free;
	assign visit_fire = (st_q == ST_VISIT) && visit_go;
	assign rsp_load  = (visit_fire && pend_valid_q) || ((st_q == ST_FINISH) && out_free);
	assign push_en   = (st_q == ST_SCAN) && (cand_q != '0) && (sp_q != SP_W'(STACK_DEPTH));
	assign pop_en    = (st_q == ST_POP) && (sp_q != '0);

	assign req_stall = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			n_q          <= CFG_W'(ROWS);
			visited_q    <= '0;
			sp_q         <= '0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			node_q       <= '0;
			cand_q       <= '0;
			pend_q       <= '0;
			rsp_q        <= '0;
			for (int r = 0; r < ROWS; r++) begin
				adj_q[r] <= '0;
			end
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				n_q <= cfg_clamped;
			end
			case (st_q)
				ST_IDLE: begin
					if (req_valid) begin
						case (req.req_type)
							REQ_WRITE_ROW: begin
								if (32'(req.node_index) < ROWS) begin
									adj_q[req.node_index[RIW-1:0]] <= req.row_bits;
								end
							end
							REQ_CLEAR: begin
								visited_q <= '0;
							end
							REQ_SEARCH: begin
								if (CFG_W'(req.node_index) < n_q) begin
									node_q <= req.node_index;
									sp_q   <= '0;
									st_q   <= ST_VISIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_VISIT: begin
					// The previous member goes out now that a later one exists.
					if (visit_go) begin
						if (pend_valid_q) begin
							rsp_q <= '{member: pend_q, last: 1'b0};
						end
						pend_q       <= node_q;
						pend_valid_q <= 1'b1;
						visited_q[node_q[RIW-1:0]] <= 1'b1;
						cand_q       <= cand_next;
						st_q         <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cand_q == '0) begin
						st_q <= ST_POP;
					end else begin
						if (push_en) begin
							sp_q <= sp_q + SP_W'(1);
						end
						cand_q <= cand_q & (cand_q - ROW_W'(1));
					end
				end
				ST_POP: begin
					if (sp_q == '0) begin
						st_q <= ST_FINISH;
					end else begin
						sp_q <= sp_dec;
						st_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (vis32[rd_q]) begin
						st_q <= ST_POP;
					end else begin
						node_q <= rd_q;
						st_q   <= ST_VISIT;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						rsp_q        <= '{member: pend_q, last: 1'b1};
						pend_valid_q <= 1'b0;
						st_q         <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			stack_mem[sp_q[SA_W-1:0]] <= low_idx;
		end
		if (pop_en) begin
			rd_q <= stack_mem[sp_dec[SA_W-1:0]];
		end
	end

	`include "graph_component_search_assert.svh"

	`GCS_ASSERT_NOW(a_sp_idle_zero, clk, arst_n, (st_q == ST_IDLE), (sp_q == '0))
	`GCS_ASSERT_NOW(a_sp_bound, clk, arst_n, 1'b1, (sp_q <= SP_W'(STACK_DEPTH)))
	`GCS_ASSERT_NOW(a_finish_has_member, clk, arst_n, (st_q == ST_FINISH), pend_valid_q)
	`GCS_ASSERT_NEXT(a_visit_marks, clk, arst_n, visit_fire, (vis32[$past(node_q)] && (st_q == ST_SCAN)))

endmodule

`default_nettype wire
